### src/cls_pkg.sv
// ============================================================================
// cls_pkg - shared definitions for the load instruction sequencer
// Types, opcode codes, register indexes, reset values and the opcode decoder.
// ============================================================================
package cls_pkg;

    // Instruction classes handled by the sequencer
    typedef enum logic [3:0] {
        K_NOP,
        K_RR,
        K_R_HL,
        K_HL_R,
        K_R_D8,
        K_HL_D8,
        K_R16_D16,
        K_ST_IND,
        K_LD_IND,
        K_LD_ABS,
        K_ST_ABS,
        K_STH_C,
        K_LDH_C,
        K_STH_N,
        K_LDH_N
    } kind_t;

    // Where the byte of the read in flight lands
    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_OPCODE = 2'd1,
        PEND_LOW    = 2'd2,
        PEND_HIGH   = 2'd3
    } pend_t;

    // One bus access word
    typedef struct packed {
        logic [15:0] bus_address;
        logic        bus_write;
        logic [7:0]  write_data;
        logic        opcode_fetch;
    } result_t;

    typedef logic [7:0] gpr_file_t [8];

    // Register file slots
    localparam logic [2:0] REG_B = 3'd0;
    localparam logic [2:0] REG_C = 3'd1;
    localparam logic [2:0] REG_D = 3'd2;
    localparam logic [2:0] REG_E = 3'd3;
    localparam logic [2:0] REG_H = 3'd4;
    localparam logic [2:0] REG_L = 3'd5;
    localparam logic [2:0] REG_M = 3'd6;  // (HL) slot, no register
    localparam logic [2:0] REG_A = 3'd7;

    // 16-bit pair selects
    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    // Opcodes and decode masks
    localparam logic [7:0] OP_HALT      = 8'h76;
    localparam logic [7:0] OP_LDH_N_ST  = 8'hE0;
    localparam logic [7:0] OP_LDH_N_LD  = 8'hF0;
    localparam logic [7:0] OP_LDH_C_ST  = 8'hE2;
    localparam logic [7:0] OP_LDH_C_LD  = 8'hF2;
    localparam logic [7:0] OP_ABS_ST    = 8'hEA;
    localparam logic [7:0] OP_ABS_LD    = 8'hFA;
    localparam logic [7:0] MASK_D8      = 8'hC7;
    localparam logic [7:0] PAT_D8       = 8'h06;
    localparam logic [7:0] MASK_PAIR    = 8'hCF;
    localparam logic [7:0] PAT_D16      = 8'h01;
    localparam logic [7:0] PAT_ST_IND   = 8'h02;
    localparam logic [7:0] PAT_LD_IND   = 8'h0A;

    localparam logic [7:0]  HIGH_PAGE   = 8'hFF;
    localparam logic [15:0] SP_RESET    = 16'hFFFE;
    localparam logic [15:0] PC_RESET    = 16'h0100;
    localparam logic [7:0]  OP_RESET    = 8'h00;

    localparam gpr_file_t GPR_RESET = '{8'h00, 8'h13, 8'h00, 8'hD8,
                                        8'h01, 8'h4D, 8'h00, 8'h01};

    // Map an opcode to its instruction class
    function automatic kind_t decode(input logic [7:0] op);
        logic [2:0] dst;
        logic [2:0] src;
        kind_t      k;
        dst = op[5:3];
        src = op[2:0];
        k   = K_NOP;
        if (op inside {[8'h40:8'h7F]})
        begin
            if (op == OP_HALT)
                k = K_NOP;
            else if (src == REG_M)
                k = K_R_HL;
            else if (dst == REG_M)
                k = K_HL_R;
            else
                k = K_RR;
        end
        else if (op < 8'h40)
        begin
            if ((op & MASK_D8) == PAT_D8)
                k = (dst == REG_M) ? K_HL_D8 : K_R_D8;
            else if ((op & MASK_PAIR) == PAT_D16)
                k = K_R16_D16;
            else if ((op & MASK_PAIR) == PAT_ST_IND)
                k = K_ST_IND;
            else if ((op & MASK_PAIR) == PAT_LD_IND)
                k = K_LD_IND;
            else
                k = K_NOP;
        end
        else
        begin
            case (op)
                OP_LDH_N_ST: k = K_STH_N;
                OP_LDH_N_LD: k = K_LDH_N;
                OP_LDH_C_ST: k = K_STH_C;
                OP_LDH_C_LD: k = K_LDH_C;
                OP_ABS_ST:   k = K_ST_ABS;
                OP_ABS_LD:   k = K_LD_ABS;
                default:     k = K_NOP;
            endcase
        end
        return k;
    endfunction

endpackage

### src/cls_in_if.sv
// ============================================================================
// cls_in_if - read data channel
// Carries the byte returned for the previous bus read.
// ============================================================================
interface cls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

### src/cls_out_if.sv
// ============================================================================
// cls_out_if - bus access channel
// Carries one bus access word per machine cycle.
// ============================================================================
interface cls_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] bus_address;
    logic        bus_write;
    logic [7:0]  write_data;
    logic        opcode_fetch;

    modport source (output valid, output bus_address, output bus_write,
                    output write_data, output opcode_fetch, input ready);
    modport sink   (input valid, input bus_address, input bus_write,
                    input write_data, input opcode_fetch, output ready);
endinterface

### src/cls_in_stage.sv
// ============================================================================
// cls_in_stage - input register
// Holds one read data word until the execute step takes it.
// ============================================================================
module cls_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    cls_in_if.sink     in,
    input  logic       take,
    output logic       vld,
    output logic [7:0] rd
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] rd_reg;

    // free when empty or being drained this cycle
    assign in.ready = !vld_reg || take;
    assign vld_next = (in.valid && in.ready) || (vld_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
            rd_reg <= in.read_data;
    end

    assign vld = vld_reg;
    assign rd  = rd_reg;

endmodule

### src/cls_exec.sv
// ============================================================================
// cls_exec - machine cycle execute step
// Applies the returned byte, then performs one cycle of the current load
// instruction and produces the bus access word for that cycle.
// ============================================================================
module cls_exec
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      rd,
    output cls_pkg::result_t res
);

    cls_pkg::gpr_file_t gpr_reg;
    cls_pkg::gpr_file_t gpr_next;
    logic [15:0]        sp_reg;
    logic [15:0]        sp_next;
    logic [15:0]        pc_reg;
    logic [15:0]        pc_next;
    logic [7:0]         op_reg;
    logic [7:0]         op_next;
    logic [7:0]         opl_reg;
    logic [7:0]         opl_next;
    logic [7:0]         oph_reg;
    logic [7:0]         oph_next;
    logic [1:0]         cyc_reg;
    logic [1:0]         cyc_next;
    cls_pkg::pend_t     pend_reg;
    cls_pkg::pend_t     pend_next;

    cls_pkg::kind_t     kind;
    logic [2:0]         dst;
    logic [2:0]         src;
    logic [1:0]         pair;
    logic [15:0]        hl;
    logic [15:0]        hl_new;
    logic [15:0]        ind_addr;
    logic [15:0]        imm16;
    logic               do_fetch;
    logic               do_imm;
    logic               do_rd;
    logic               do_wr;
    logic [15:0]        acc_addr;
    logic [7:0]         wr_data;
    cls_pkg::pend_t     tgt;

    // land the returned byte first
    always_comb
    begin
        op_next  = (pend_reg == cls_pkg::PEND_OPCODE) ? rd : op_reg;
        opl_next = (pend_reg == cls_pkg::PEND_LOW)    ? rd : opl_reg;
        oph_next = (pend_reg == cls_pkg::PEND_HIGH)   ? rd : oph_reg;
    end

    assign kind  = cls_pkg::decode(op_next);
    assign dst   = op_next[5:3];
    assign src   = op_next[2:0];
    assign pair  = op_next[5:4];
    assign hl    = {gpr_reg[cls_pkg::REG_H], gpr_reg[cls_pkg::REG_L]};
    assign imm16 = {oph_next, opl_next};

    // (BC), (DE), (HL+), (HL-) addressing
    always_comb
    begin
        case (pair)
            cls_pkg::PAIR_BC: ind_addr = {gpr_reg[cls_pkg::REG_B], gpr_reg[cls_pkg::REG_C]};
            cls_pkg::PAIR_DE: ind_addr = {gpr_reg[cls_pkg::REG_D], gpr_reg[cls_pkg::REG_E]};
            default:          ind_addr = hl;
        endcase
        hl_new = (pair == cls_pkg::PAIR_HL) ? hl + 16'd1 : hl - 16'd1;
    end

    // per-class cycle actions and register updates
    always_comb
    begin
        gpr_next = gpr_reg;
        sp_next  = sp_reg;
        do_fetch = 1'b0;
        do_imm   = 1'b0;
        do_rd    = 1'b0;
        do_wr    = 1'b0;
        acc_addr = hl;
        wr_data  = '0;
        tgt      = cls_pkg::PEND_LOW;
        case (kind)
            cls_pkg::K_RR:
            begin
                gpr_next[dst] = gpr_reg[src];
                do_fetch      = 1'b1;
            end
            cls_pkg::K_R_HL:
            begin
                if (cyc_reg == 2'd0)
                    do_rd = 1'b1;
                else
                begin
                    gpr_next[dst] = opl_next;
                    do_fetch      = 1'b1;
                end
            end
            cls_pkg::K_HL_R:
            begin
                if (cyc_reg == 2'd0)
                begin
                    do_wr   = 1'b1;
                    wr_data = gpr_reg[src];
                end
                else
                    do_fetch = 1'b1;
            end
            cls_pkg::K_R_D8:
            begin
                if (cyc_reg == 2'd0)
                    do_imm = 1'b1;
                else
                begin
                    gpr_next[dst] = opl_next;
                    do_fetch      = 1'b1;
                end
            end
            cls_pkg::K_HL_D8:
            begin
                if (cyc_reg == 2'd0)
                    do_imm = 1'b1;
                else if (cyc_reg == 2'd1)
                begin
                    do_wr   = 1'b1;
                    wr_data = opl_next;
                end
                else
                    do_fetch = 1'b1;
            end
            cls_pkg::K_R16_D16:
            begin
                if (cyc_reg == 2'd0)
                    do_imm = 1'b1;
                else if (cyc_reg == 2'd1)
                begin
                    do_imm = 1'b1;
                    tgt    = cls_pkg::PEND_HIGH;
                end
                else
                begin
                    if (pair == cls_pkg::PAIR_SP)
                        sp_next = imm16;
                    else
                    begin
                        gpr_next[{pair, 1'b0}] = oph_next;
                        gpr_next[{pair, 1'b1}] = opl_next;
                    end
                    do_fetch = 1'b1;
                end
            end
            cls_pkg::K_ST_IND, cls_pkg::K_LD_IND:
            begin
                if (cyc_reg == 2'd0)
                begin
                    acc_addr = ind_addr;
                    if (pair == cls_pkg::PAIR_HL || pair == cls_pkg::PAIR_SP)
                    begin
                        gpr_next[cls_pkg::REG_H] = hl_new[15:8];
                        gpr_next[cls_pkg::REG_L] = hl_new[7:0];
                    end
                    if (kind == cls_pkg::K_ST_IND)
                    begin
                        do_wr   = 1'b1;
                        wr_data = gpr_reg[cls_pkg::REG_A];
                    end
                    else
                        do_rd = 1'b1;
                end
                else
                begin
                    if (kind == cls_pkg::K_LD_IND)
                        gpr_next[cls_pkg::REG_A] = opl_next;
                    do_fetch = 1'b1;
                end
            end
            cls_pkg::K_LD_ABS, cls_pkg::K_ST_ABS:
            begin
                acc_addr = imm16;
                if (cyc_reg == 2'd0)
                    do_imm = 1'b1;
                else if (cyc_reg == 2'd1)
                begin
                    do_imm = 1'b1;
                    tgt    = cls_pkg::PEND_HIGH;
                end
                else if (cyc_reg == 2'd2)
                begin
                    if (kind == cls_pkg::K_ST_ABS)
                    begin
                        do_wr   = 1'b1;
                        wr_data = gpr_reg[cls_pkg::REG_A];
                    end
                    else
                        do_rd = 1'b1;
                end
                else
                begin
                    if (kind == cls_pkg::K_LD_ABS)
                        gpr_next[cls_pkg::REG_A] = opl_next;
                    do_fetch = 1'b1;
                end
            end
            cls_pkg::K_STH_C, cls_pkg::K_LDH_C:
            begin
                acc_addr = {cls_pkg::HIGH_PAGE, gpr_reg[cls_pkg::REG_C]};
                if (cyc_reg == 2'd0)
                begin
                    if (kind == cls_pkg::K_STH_C)
                    begin
                        do_wr   = 1'b1;
                        wr_data = gpr_reg[cls_pkg::REG_A];
                    end
                    else
                        do_rd = 1'b1;
                end
                else
                begin
                    if (kind == cls_pkg::K_LDH_C)
                        gpr_next[cls_pkg::REG_A] = opl_next;
                    do_fetch = 1'b1;
                end
            end
            cls_pkg::K_STH_N, cls_pkg::K_LDH_N:
            begin
                acc_addr = {cls_pkg::HIGH_PAGE, opl_next};
                if (cyc_reg == 2'd0)
                    do_imm = 1'b1;
                else if (cyc_reg == 2'd1)
                begin
                    if (kind == cls_pkg::K_STH_N)
                    begin
                        do_wr   = 1'b1;
                        wr_data = gpr_reg[cls_pkg::REG_A];
                    end
                    else
                        do_rd = 1'b1;
                end
                else
                begin
                    if (kind == cls_pkg::K_LDH_N)
                        gpr_next[cls_pkg::REG_A] = opl_next;
                    do_fetch = 1'b1;
                end
            end
            default:
                do_fetch = 1'b1;
        endcase
    end

    // build the bus access word and PC/pending updates
    always_comb
    begin
        res       = '0;
        pc_next   = pc_reg;
        pend_next = cls_pkg::PEND_NONE;
        if (do_fetch)
        begin
            res.bus_address  = pc_reg;
            res.opcode_fetch = 1'b1;
            pend_next        = cls_pkg::PEND_OPCODE;
            pc_next          = pc_reg + 16'd1;
        end
        else if (do_imm)
        begin
            res.bus_address = pc_reg;
            pend_next       = tgt;
            pc_next         = pc_reg + 16'd1;
        end
        else if (do_rd)
        begin
            res.bus_address = acc_addr;
            pend_next       = tgt;
        end
        else if (do_wr)
        begin
            res.bus_address = acc_addr;
            res.bus_write   = 1'b1;
            res.write_data  = wr_data;
        end
        cyc_next = do_fetch ? 2'd0 : cyc_reg + 2'd1;
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpr_reg  <= cls_pkg::GPR_RESET;
            sp_reg   <= cls_pkg::SP_RESET;
            pc_reg   <= cls_pkg::PC_RESET;
            op_reg   <= cls_pkg::OP_RESET;
            opl_reg  <= '0;
            oph_reg  <= '0;
            cyc_reg  <= '0;
            pend_reg <= cls_pkg::PEND_NONE;
        end
        else if (take)
        begin
            gpr_reg  <= gpr_next;
            sp_reg   <= sp_next;
            pc_reg   <= pc_next;
            op_reg   <= op_next;
            opl_reg  <= opl_next;
            oph_reg  <= oph_next;
            cyc_reg  <= cyc_next;
            pend_reg <= pend_next;
        end
    end

endmodule

### src/cls_out_stage.sv
// ============================================================================
// cls_out_stage - result register
// Holds one bus access word until the downstream side takes it.
// ============================================================================
module cls_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cls_pkg::result_t res,
    output logic             can_load,
    cls_out_if.source        out
);

    logic             vld_reg;
    logic             vld_next;
    cls_pkg::result_t res_reg;

    // room when empty or the word leaves this cycle
    assign can_load = !vld_reg || out.ready;
    assign vld_next = load || (vld_reg && !out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out.valid        = vld_reg;
    assign out.bus_address  = res_reg.bus_address;
    assign out.bus_write    = res_reg.bus_write;
    assign out.write_data   = res_reg.write_data;
    assign out.opcode_fetch = res_reg.opcode_fetch;

endmodule

### src/cpu_load_instruction_sequencer.sv
// ============================================================================
// cpu_load_instruction_sequencer - load instruction sequencer top level
// Runs the load subset of an 8-bit CPU one machine cycle per word.
// ============================================================================
// Each word on in carries the byte returned for the read issued by the
// previous word on out (ignored after a write); each word on out is one bus
// access: a data read, a data write or an opcode fetch, with the fetch of the
// next opcode overlapping the last cycle of every instruction. One word is
// taken per clock while out does not stall: the execute step is combinational
// between the input register and the result register, so the sustained rate
// is one word per cycle when out is ready. A word taken on in is held in the
// input register, then its result word in the result register; a stall on out
// holds the result register and at most one more word in the input register.
// Instructions take their real machine cycle counts, one word each; unlisted
// opcodes, halt included, only fetch the next opcode. After reset the first
// word out fetches the opcode at 0x0100.
module cpu_load_instruction_sequencer
(
    input  logic      clk,
    input  logic      rst_n,
    cls_in_if.sink    in,
    cls_out_if.source out
);

    logic             in_vld;
    logic [7:0]       in_rd;
    logic             can_load;
    logic             take;
    cls_pkg::result_t res;

    assign take = in_vld && can_load;

    cls_in_stage u_in_stage
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in),
        .take  (take),
        .vld   (in_vld),
        .rd    (in_rd)
    );

    cls_exec u_exec
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .rd    (in_rd),
        .res   (res)
    );

    cls_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .res      (res),
        .can_load (can_load),
        .out      (out)
    );

endmodule

### tb/tb_top.sv
// ============================================================================
// tb_top - load instruction sequencer testbench
// Plays the memory side of the sequencer: opcodes and operand bytes are fed
// back as read data, a cycle-accurate predictor tracks registers, PC and the
// instruction stage, and every bus word is checked field by field.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcode field encodings used to build instructions
    localparam logic [1:0] ROW_MISC    = 2'b00;
    localparam logic [1:0] ROW_MOVE    = 2'b01;
    localparam logic [3:0] LO_D16      = 4'h1;
    localparam logic [3:0] LO_ST_IND   = 4'h2;
    localparam logic [3:0] LO_LD_IND   = 4'hA;
    localparam logic [1:0] PTR_BC      = 2'd0;
    localparam logic [1:0] PTR_DE      = 2'd1;
    localparam logic [1:0] PTR_HLI     = 2'd2;
    localparam logic [1:0] PTR_HLD     = 2'd3;
    localparam logic [7:0] OP_UNLISTED = 8'hD3;

    logic clk;
    logic rst_n;

    cls_in_if  rd_bus ();
    cls_out_if acc_bus ();

    cpu_load_instruction_sequencer dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (rd_bus),
        .out   (acc_bus)
    );

    // Predicted CPU state
    cls_pkg::gpr_file_t regs_m;
    logic [15:0]        sp_m;
    logic [15:0]        pc_m;
    logic [7:0]         ir_m;
    logic [7:0]         lo_m;
    logic [7:0]         hi_m;
    logic [1:0]         step_m;
    cls_pkg::pend_t     pend_m;

    cls_pkg::result_t   bus_words_due [$];
    cls_pkg::result_t   last_word;

    int          errors;
    int          data_words;
    int          instr_count;
    int          fetch_words;
    int          read_words;
    int          write_words;
    int unsigned hold;
    bit          no_idle;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic cls_pkg::kind_t classify(input logic [7:0] op);
        cls_pkg::kind_t k;
        k = cls_pkg::K_NOP;
        if (op == cls_pkg::OP_HALT)
            k = cls_pkg::K_NOP;
        else if (op[7:6] == ROW_MOVE)
            k = (op[2:0] == cls_pkg::REG_M) ? cls_pkg::K_R_HL :
                ((op[5:3] == cls_pkg::REG_M) ? cls_pkg::K_HL_R : cls_pkg::K_RR);
        else if (op[7:6] == ROW_MISC)
        begin
            if (op[2:0] == cls_pkg::REG_M)
                k = (op[5:3] == cls_pkg::REG_M) ? cls_pkg::K_HL_D8 : cls_pkg::K_R_D8;
            else if (op[3:0] == LO_D16)
                k = cls_pkg::K_R16_D16;
            else if (op[3:0] == LO_ST_IND)
                k = cls_pkg::K_ST_IND;
            else if (op[3:0] == LO_LD_IND)
                k = cls_pkg::K_LD_IND;
        end
        else
        begin
            case (op)
                cls_pkg::OP_LDH_N_ST: k = cls_pkg::K_STH_N;
                cls_pkg::OP_LDH_N_LD: k = cls_pkg::K_LDH_N;
                cls_pkg::OP_LDH_C_ST: k = cls_pkg::K_STH_C;
                cls_pkg::OP_LDH_C_LD: k = cls_pkg::K_LDH_C;
                cls_pkg::OP_ABS_ST:   k = cls_pkg::K_ST_ABS;
                cls_pkg::OP_ABS_LD:   k = cls_pkg::K_LD_ABS;
                default:              k = cls_pkg::K_NOP;
            endcase
        end
        return k;
    endfunction

    function automatic cls_pkg::result_t read_word(input logic [15:0] addr,
                                                   input cls_pkg::pend_t tgt);
        cls_pkg::result_t w;
        w = '0;
        w.bus_address = addr;
        pend_m = tgt;
        return w;
    endfunction

    // Immediate byte read at PC
    function automatic cls_pkg::result_t operand_word(input cls_pkg::pend_t tgt);
        cls_pkg::result_t w;
        w = read_word(pc_m, tgt);
        pc_m = pc_m + 16'd1;
        return w;
    endfunction

    function automatic cls_pkg::result_t write_word(input logic [15:0] addr,
                                                    input logic [7:0] data);
        cls_pkg::result_t w;
        w = '0;
        w.bus_address = addr;
        w.bus_write = 1'b1;
        w.write_data = data;
        pend_m = cls_pkg::PEND_NONE;
        return w;
    endfunction

    function automatic cls_pkg::result_t fetch_word();
        cls_pkg::result_t w;
        w = '0;
        w.bus_address = pc_m;
        w.opcode_fetch = 1'b1;
        pend_m = cls_pkg::PEND_OPCODE;
        pc_m = pc_m + 16'd1;
        return w;
    endfunction

    function automatic void load_pair(input logic [1:0] idx, input logic [15:0] v);
        if (idx == cls_pkg::PAIR_SP)
            sp_m = v;
        else
        begin
            regs_m[{idx, 1'b0}] = v[15:8];
            regs_m[{idx, 1'b1}] = v[7:0];
        end
    endfunction

    // (BC), (DE), (HL+), (HL-): HL steps after its value is taken
    function automatic logic [15:0] pointer_addr(input logic [1:0] idx);
        logic [15:0] hl;
        hl = {regs_m[cls_pkg::REG_H], regs_m[cls_pkg::REG_L]};
        case (idx)
            PTR_BC:  return {regs_m[cls_pkg::REG_B], regs_m[cls_pkg::REG_C]};
            PTR_DE:  return {regs_m[cls_pkg::REG_D], regs_m[cls_pkg::REG_E]};
            PTR_HLI: load_pair(cls_pkg::PAIR_HL, hl + 16'd1);
            default: load_pair(cls_pkg::PAIR_HL, hl - 16'd1);
        endcase
        return hl;
    endfunction

    // One machine cycle: apply the returned byte, then one bus access
    function automatic cls_pkg::result_t run_machine_cycle(input logic [7:0] rd);
        cls_pkg::result_t w;
        cls_pkg::kind_t   k;
        logic [2:0]       dst;
        logic [2:0]       src;
        logic [1:0]       st;
        logic [15:0]      hl;
        case (pend_m)
            cls_pkg::PEND_OPCODE: ir_m = rd;
            cls_pkg::PEND_LOW:    lo_m = rd;
            cls_pkg::PEND_HIGH:   hi_m = rd;
            default:              ;
        endcase
        pend_m = cls_pkg::PEND_NONE;
        k   = classify(ir_m);
        dst = ir_m[5:3];
        src = ir_m[2:0];
        st  = step_m;
        hl  = {regs_m[cls_pkg::REG_H], regs_m[cls_pkg::REG_L]};
        w   = '0;
        case (k)
            cls_pkg::K_RR:
            begin
                regs_m[dst] = regs_m[src];
                w = fetch_word();
            end
            cls_pkg::K_R_HL:
                if (st == 0)
                    w = read_word(hl, cls_pkg::PEND_LOW);
                else
                begin
                    regs_m[dst] = lo_m;
                    w = fetch_word();
                end
            cls_pkg::K_HL_R:
                w = (st == 0) ? write_word(hl, regs_m[src]) : fetch_word();
            cls_pkg::K_R_D8:
                if (st == 0)
                    w = operand_word(cls_pkg::PEND_LOW);
                else
                begin
                    regs_m[dst] = lo_m;
                    w = fetch_word();
                end
            cls_pkg::K_HL_D8:
                if (st == 0)
                    w = operand_word(cls_pkg::PEND_LOW);
                else if (st == 1)
                    w = write_word(hl, lo_m);
                else
                    w = fetch_word();
            cls_pkg::K_R16_D16:
                if (st == 0)
                    w = operand_word(cls_pkg::PEND_LOW);
                else if (st == 1)
                    w = operand_word(cls_pkg::PEND_HIGH);
                else
                begin
                    load_pair(ir_m[5:4], {hi_m, lo_m});
                    w = fetch_word();
                end
            cls_pkg::K_ST_IND:
                if (st == 0)
                    w = write_word(pointer_addr(ir_m[5:4]), regs_m[cls_pkg::REG_A]);
                else
                    w = fetch_word();
            cls_pkg::K_LD_IND:
                if (st == 0)
                    w = read_word(pointer_addr(ir_m[5:4]), cls_pkg::PEND_LOW);
                else
                begin
                    regs_m[cls_pkg::REG_A] = lo_m;
                    w = fetch_word();
                end
            cls_pkg::K_LD_ABS:
                if (st == 0)
                    w = operand_word(cls_pkg::PEND_LOW);
                else if (st == 1)
                    w = operand_word(cls_pkg::PEND_HIGH);
                else if (st == 2)
                    w = read_word({hi_m, lo_m}, cls_pkg::PEND_LOW);
                else
                begin
                    regs_m[cls_pkg::REG_A] = lo_m;
                    w = fetch_word();
                end
            cls_pkg::K_ST_ABS:
                if (st == 0)
                    w = operand_word(cls_pkg::PEND_LOW);
                else if (st == 1)
                    w = operand_word(cls_pkg::PEND_HIGH);
                else if (st == 2)
                    w = write_word({hi_m, lo_m}, regs_m[cls_pkg::REG_A]);
                else
                    w = fetch_word();
            cls_pkg::K_STH_C:
                if (st == 0)
                    w = write_word({cls_pkg::HIGH_PAGE, regs_m[cls_pkg::REG_C]},
                                   regs_m[cls_pkg::REG_A]);
                else
                    w = fetch_word();
            cls_pkg::K_LDH_C:
                if (st == 0)
                    w = read_word({cls_pkg::HIGH_PAGE, regs_m[cls_pkg::REG_C]},
                                  cls_pkg::PEND_LOW);
                else
                begin
                    regs_m[cls_pkg::REG_A] = lo_m;
                    w = fetch_word();
                end
            cls_pkg::K_STH_N:
                if (st == 0)
                    w = operand_word(cls_pkg::PEND_LOW);
                else if (st == 1)
                    w = write_word({cls_pkg::HIGH_PAGE, lo_m}, regs_m[cls_pkg::REG_A]);
                else
                    w = fetch_word();
            cls_pkg::K_LDH_N:
                if (st == 0)
                    w = operand_word(cls_pkg::PEND_LOW);
                else if (st == 1)
                    w = read_word({cls_pkg::HIGH_PAGE, lo_m}, cls_pkg::PEND_LOW);
                else
                begin
                    regs_m[cls_pkg::REG_A] = lo_m;
                    w = fetch_word();
                end
            default:
                w = fetch_word();
        endcase
        step_m = w.opcode_fetch ? 2'd0 : st + 2'd1;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    // Mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Data byte with extra weight on the extremes
    function automatic logic [7:0] rand_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Any register slot except the (HL) slot
    function automatic logic [2:0] any_reg();
        logic [2:0] v;
        v = 3'($urandom_range(0, 6));
        if (v >= cls_pkg::REG_M)
            v = v + 3'd1;
        return v;
    endfunction

    function automatic logic [7:0] pick_opcode();
        logic [7:0] op;
        case ($urandom_range(0, 15))
            0:       op = {ROW_MOVE, any_reg(), any_reg()};
            1:       op = {ROW_MOVE, any_reg(), cls_pkg::REG_M};
            2:       op = {ROW_MOVE, cls_pkg::REG_M, any_reg()};
            3:       op = {ROW_MISC, any_reg(), cls_pkg::REG_M};
            4:       op = {ROW_MISC, cls_pkg::REG_M, cls_pkg::REG_M};
            5:       op = {ROW_MISC, 2'($urandom_range(0, 3)), LO_D16};
            6:       op = {ROW_MISC, 2'($urandom_range(0, 3)), LO_ST_IND};
            7:       op = {ROW_MISC, 2'($urandom_range(0, 3)), LO_LD_IND};
            8:       op = cls_pkg::OP_ABS_LD;
            9:       op = cls_pkg::OP_ABS_ST;
            10:      op = cls_pkg::OP_LDH_C_ST;
            11:      op = cls_pkg::OP_LDH_C_LD;
            12:      op = cls_pkg::OP_LDH_N_ST;
            13:      op = cls_pkg::OP_LDH_N_LD;
            14:      op = cls_pkg::OP_HALT;
            default: op = 8'($urandom_range(0, 255));
        endcase
        return op;
    endfunction

    // ------------------------------------------------------------------------
    // Read data side
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] d);
        int unsigned gap;
        data_words++;
        rd_bus.valid     <= 1'b1;
        rd_bus.read_data <= d;
        do
            @(posedge clk);
        while (!rd_bus.ready);
        last_word = run_machine_cycle(d);
        bus_words_due.push_back(last_word);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            rd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Opcode, then operand/data bytes until the next fetch goes out
    task automatic exec_instr(input logic [7:0] op, input logic [7:0] b0,
                              input logic [7:0] b1, input logic [7:0] b2);
        logic [7:0] tail [3];
        int         i;
        tail[0] = b0;
        tail[1] = b1;
        tail[2] = b2;
        i = 0;
        instr_count++;
        send_word(op);
        while (!last_word.opcode_fetch && i < 3)
        begin
            send_word(tail[i]);
            i++;
        end
    endtask

    task automatic wait_drained();
        rd_bus.valid <= 1'b0;
        while (bus_words_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Bus access side: random stalls and checking
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : access_sink
        cls_pkg::result_t want;
        if (rst_n && acc_bus.valid && acc_bus.ready)
        begin
            if (bus_words_due.size() == 0)
            begin
                errors++;
                $display("%0t ns: bus word with none expected, expected none, actual %h",
                         $time, acc_bus.bus_address);
            end
            else
            begin
                want = bus_words_due.pop_front();
                compare_field("bus_address", want.bus_address, acc_bus.bus_address);
                compare_field("bus_write", want.bus_write, acc_bus.bus_write);
                compare_field("write_data", want.write_data, acc_bus.write_data);
                compare_field("opcode_fetch", want.opcode_fetch, acc_bus.opcode_fetch);
                if (want.opcode_fetch)
                    fetch_words++;
                else if (want.bus_write)
                    write_words++;
                else
                    read_words++;
            end
        end
        if (no_idle || hold == 0)
        begin
            acc_bus.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 2) == 0)
                hold = pick_gap();
        end
        else
        begin
            acc_bus.ready <= 1'b0;
            hold--;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // First word after reset fetches at 0x0100, its read data is dropped
    task automatic test_reset_fetch();
        send_word(rand_byte());
    endtask

    // Each load form once, with HL wrapping both ways
    task automatic test_each_load();
        exec_instr({ROW_MISC, cls_pkg::PAIR_HL, LO_D16}, 8'hFF, 8'hFF, 8'h00);
        exec_instr({ROW_MISC, PTR_HLI, LO_ST_IND}, 8'h00, 8'h00, 8'h00);
        exec_instr({ROW_MISC, PTR_HLD, LO_LD_IND}, 8'hFF, 8'h00, 8'h00);
        exec_instr({ROW_MISC, cls_pkg::REG_B, cls_pkg::REG_M}, 8'h00, 8'h00, 8'h00);
        exec_instr({ROW_MISC, cls_pkg::REG_M, cls_pkg::REG_M}, 8'hFF, 8'h00, 8'h00);
        exec_instr({ROW_MOVE, cls_pkg::REG_C, cls_pkg::REG_M}, 8'h80, 8'h00, 8'h00);
        exec_instr({ROW_MOVE, cls_pkg::REG_M, cls_pkg::REG_B}, 8'hFF, 8'h00, 8'h00);
        exec_instr({ROW_MOVE, cls_pkg::REG_E, cls_pkg::REG_A}, 8'h00, 8'h00, 8'h00);
        exec_instr(cls_pkg::OP_ABS_LD, 8'h00, 8'h00, 8'h5A);
        exec_instr(cls_pkg::OP_ABS_ST, 8'hFF, 8'hFF, 8'h00);
        exec_instr(cls_pkg::OP_LDH_C_ST, 8'h00, 8'h00, 8'h00);
        exec_instr(cls_pkg::OP_LDH_C_LD, 8'hA5, 8'h00, 8'h00);
        exec_instr(cls_pkg::OP_LDH_N_ST, 8'hFF, 8'h00, 8'h00);
        exec_instr(cls_pkg::OP_LDH_N_LD, 8'h00, 8'h3C, 8'h00);
        exec_instr(cls_pkg::OP_HALT, 8'h00, 8'h00, 8'h00);
        exec_instr(OP_UNLISTED, 8'h00, 8'h00, 8'h00);
    endtask

    // Random instruction stream with random operands and data
    task automatic test_random_program(input int words);
        int first;
        first = data_words;
        while (data_words - first < words)
        begin
            if ($urandom_range(0, 59) == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            exec_instr(pick_opcode(), rand_byte(), rand_byte(), rand_byte());
        end
        no_idle = 1'b0;
    endtask

    // Sender holds off until the access side has caught up
    task automatic test_pause_until_drained();
        wait_drained();
        exec_instr(pick_opcode(), rand_byte(), rand_byte(), rand_byte());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        rd_bus.valid      = 1'b0;
        rd_bus.read_data  = 8'h00;
        acc_bus.ready     = 1'b0;
        errors            = 0;
        data_words        = 0;
        instr_count       = 0;
        fetch_words       = 0;
        read_words        = 0;
        write_words       = 0;
        hold              = 0;
        no_idle           = 1'b0;
        regs_m = '{8'h00, 8'h13, 8'h00, 8'hD8, 8'h01, 8'h4D, 8'h00, 8'h01};
        sp_m   = 16'hFFFE;
        pc_m   = 16'h0100;
        ir_m   = 8'h00;
        lo_m   = 8'h00;
        hi_m   = 8'h00;
        step_m = 2'd0;
        pend_m = cls_pkg::PEND_NONE;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_fetch();
        test_each_load();
        test_random_program(900);
        test_pause_until_drained();
        test_random_program(950);

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Run: %0d instructions, %0d read data words, %0d bus words checked",
                 instr_count, data_words, fetch_words + read_words + write_words);
        $display("Run: %0d fetches, %0d reads, %0d writes; every load form, HL step wrap,",
                 fetch_words, read_words, write_words);
        $display("     high page, absolute, random stalls on both sides");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
src/cls_pkg.sv
src/cls_in_if.sv
src/cls_out_if.sv
src/cls_in_stage.sv
src/cls_exec.sv
src/cls_out_stage.sv
src/cpu_load_instruction_sequencer.sv
tb/tb_top.sv
